[src/tactile_baseline_contact_detector_unit_defines.svh]
// assertion macros for the tactile detector back end rtl
// no dependencies; included by modules that carry checks
`ifndef TACTILE_BASELINE_CONTACT_DETECTOR_UNIT_DEFINES_SVH
`define TACTILE_BASELINE_CONTACT_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication under active-low reset
`define TBCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbcd check failed");

// next-cycle implication under active-low reset
`define TBCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbcd check failed");

`endif

[src/tbcd_pkg.sv]
// types, constants and saturation helpers for the tactile detector
// no dependencies; used by every module of the block except tbcd_div
`timescale 1ns / 1ps

package tbcd_pkg;

    localparam int FINGERS_DEF          = 3;
    localparam int ELECTRODES_USED_DEF  = 19;
    localparam int ELECTRODE_SLOTS_DEF  = 24;
    localparam int WORDS_PER_FINGER_DEF = 54;
    localparam int QUEUE_DEPTH          = 4;

    localparam int FW  = 2;
    localparam int SW  = 6;
    localparam int VW  = 12;
    localparam int KW  = 5;
    localparam int GW  = 17;
    localparam int DTW = 16;
    localparam int CFW = 10;
    localparam int FCW = 11;
    localparam int LW  = 32;
    localparam int TW  = 24;
    localparam int CIW = 2;
    localparam int CDW = 17;
    localparam int SQW = 29;

    localparam logic [CIW-1:0] CFG_FILTER_GAIN  = 2'd0;
    localparam logic [CIW-1:0] CFG_INV_DT       = 2'd1;
    localparam logic [CIW-1:0] CFG_CALIB_FRAMES = 2'd2;

    localparam logic [GW-1:0]  GAIN_RST   = 17'd6554;
    localparam logic [DTW-1:0] INVDT_RST  = 16'd100;
    localparam logic [CFW-1:0] CALIB_RST  = 10'd100;
    localparam logic [GW-1:0]  GAIN_ONE   = 17'd65536;
    localparam logic [GW-1:0]  GAIN_RATE  = 17'd13107;
    localparam logic [GW-1:0]  GAIN_TRACK = 17'd6554;

    localparam logic signed [32:0] NEAR_LIMIT = 33'sd81920;
    localparam logic signed [32:0] RATE_LIMIT = 33'sd307200;
    localparam logic signed [32:0] ONE_Q12    = 33'sd4096;
    localparam logic [SQW-1:0]     ONE_SQ     = 29'd16777216;

    typedef enum logic [1:0] {
        K_ELEC,
        K_PRES,
        K_TEMP
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [FW-1:0]   f;
        logic [KW-1:0]   e;
        logic [VW-1:0]   v;
    } t_cmd;

    typedef struct packed {
        logic [GW-1:0]  gain;
        logic [DTW-1:0] inv_dt;
        logic [CFW-1:0] calib;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EC_RD,
        ST_EC_WR,
        ST_P_RMUL,
        ST_P_FMUL,
        ST_P_RADD,
        ST_P_BMUL,
        ST_P_BADD,
        ST_P_ERD,
        ST_P_EMUL,
        ST_P_EADD,
        ST_P_FMUL2,
        ST_P_FADD,
        ST_T_CAL,
        ST_AV_RD,
        ST_AV_GO,
        ST_AV_WAIT,
        ST_T_MUL,
        ST_T_ADD,
        ST_E_RD,
        ST_E_MUL,
        ST_E_ADD,
        ST_E_SQ,
        ST_E_DONE,
        ST_O_RD,
        ST_O_LOAD,
        ST_O_WAIT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic [VW-1:0] val);
        logic signed [63:0] s;
        s = 64'(a) + $signed({52'd0, val});
        return sat32(s);
    endfunction

endpackage

[src/tbcd_front.sv]
// front end: accepts sample words and classifies them into commands
// depends on tbcd_pkg
`timescale 1ns / 1ps

module tbcd_front #(
    parameter int FINGERS          = tbcd_pkg::FINGERS_DEF,
    parameter int ELECTRODES_USED  = tbcd_pkg::ELECTRODES_USED_DEF,
    parameter int ELECTRODE_SLOTS  = tbcd_pkg::ELECTRODE_SLOTS_DEF,
    parameter int WORDS_PER_FINGER = tbcd_pkg::WORDS_PER_FINGER_DEF
) (
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [tbcd_pkg::FW-1:0] i_finger_index,
    input  logic [tbcd_pkg::SW-1:0] i_slot,
    input  logic [tbcd_pkg::VW-1:0] i_sample_value,
    input  logic                    i_full,
    output logic                    o_push,
    output tbcd_pkg::t_cmd          o_cmd
);

    logic in_range;
    logic is_el;
    logic is_p;
    logic is_t;

    always_comb begin
        in_range = (int'(i_finger_index) < FINGERS) && (int'(i_slot) < WORDS_PER_FINGER);
        is_el    = (int'(i_slot) < 2 * ELECTRODE_SLOTS) && !i_slot[0]
                   && (int'(i_slot[tbcd_pkg::SW-1:1]) < ELECTRODES_USED);
        is_p     = int'(i_slot) == 2 * ELECTRODE_SLOTS;
        is_t     = int'(i_slot) == 2 * ELECTRODE_SLOTS + 4;

        o_ready    = !i_full;
        o_push     = i_valid && !i_full && in_range && (is_el || is_p || is_t);
        o_cmd.f    = i_finger_index;
        o_cmd.e    = i_slot[tbcd_pkg::SW-1:1];
        o_cmd.v    = i_sample_value;
        if (is_p) begin
            o_cmd.kind = tbcd_pkg::K_PRES;
        end else if (is_t) begin
            o_cmd.kind = tbcd_pkg::K_TEMP;
        end else begin
            o_cmd.kind = tbcd_pkg::K_ELEC;
        end
    end

endmodule

[src/tbcd_queue.sv]
// short command queue between front and back end
// depends on tbcd_pkg
`timescale 1ns / 1ps

module tbcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbcd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tbcd_pkg::t_cmd o_data
);

    localparam int DEPTH = tbcd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tbcd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[src/tbcd_div.sv]
// calibration averager: round((sum * 4096) / n), negative sums as 0, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module tbcd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_sum,
    input  logic [10:0]        i_n,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int NW = 44;

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_q;
    logic [10:0]   r_rem;
    logic [10:0]   r_n;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [11:0]   trial;
    logic          ge;
    logic [NW-1:0] start_num;

    always_comb begin
        trial     = {r_rem, r_num[NW-1]};
        ge        = trial >= {1'b0, r_n};
        start_num = ((i_sum < 0) ? '0 : (NW'(i_sum[30:0]) << 12)) + NW'(i_n >> 1);
        o_done    = r_done;
        o_quot    = (r_q[NW-1:31] != '0) ? 32'sh7FFFFFFF : $signed({1'b0, r_q[30:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= start_num;
            r_n   <= i_n;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? 11'(trial - {1'b0, r_n}) : trial[10:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[src/tbcd_back.sv]
// back end: per-fingertip filters, baselines, contact and result sequencing
// depends on tbcd_pkg, tbcd_div and the assertion macro header
`timescale 1ns / 1ps
`include "tactile_baseline_contact_detector_unit_defines.svh"

module tbcd_back #(
    parameter int FINGERS         = tbcd_pkg::FINGERS_DEF,
    parameter int ELECTRODES_USED = tbcd_pkg::ELECTRODES_USED_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tbcd_pkg::t_cfg           i_cfg,
    input  logic                     i_q_empty,
    input  tbcd_pkg::t_cmd           i_q_data,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [tbcd_pkg::FW-1:0]  o_finger_num,
    output logic [tbcd_pkg::KW-1:0]  o_electrode_index,
    output logic signed [31:0]       o_electrode_level,
    output logic signed [31:0]       o_pressure_above_baseline,
    output logic [tbcd_pkg::TW-1:0]  o_temperature_level,
    output logic                     o_contact,
    output logic                     o_active,
    output logic                     o_last
);

    localparam int NE = FINGERS * ELECTRODES_USED;
    localparam int AW = (NE > 1) ? $clog2(NE) : 1;
    localparam int EW = (ELECTRODES_USED > 1) ? $clog2(ELECTRODES_USED) : 1;

    tbcd_pkg::t_state r_state;
    tbcd_pkg::t_state n_state;
    tbcd_pkg::t_cmd   r_cmd;

    logic                     r_cal;
    logic [tbcd_pkg::FCW-1:0] r_fc;
    logic signed [31:0]       r_pf   [FINGERS];
    logic signed [31:0]       r_pb   [FINGERS];
    logic signed [31:0]       r_rate [FINGERS];
    logic signed [31:0]       r_tf   [FINGERS];
    logic [FINGERS-1:0]       r_contact;
    logic [FINGERS-1:0]       r_active;
    logic [tbcd_pkg::VW-1:0]  r_cap  [ELECTRODES_USED];

    logic [31:0]   r_eb_mem [NE];
    logic [31:0]   r_ef_mem [NE];
    logic [NE-1:0] r_eb_vld;
    logic [NE-1:0] r_ef_vld;
    logic [31:0]   r_eb_q;
    logic [31:0]   r_ef_q;
    logic          r_eb_qv;
    logic          r_ef_qv;

    logic signed [51:0]       r_prod;
    logic signed [31:0]       r_y;
    logic [tbcd_pkg::KW-1:0]  r_k;
    logic [1:0]               r_sel;
    logic                     r_show;
    logic                     r_act;
    logic [tbcd_pkg::VW-1:0]  r_abs;
    logic [tbcd_pkg::SQW-1:0] r_sq;
    logic                     r_oval;

    logic signed [33:0]       mul_a;
    logic [tbcd_pkg::GW-1:0]  mul_b;
    logic [tbcd_pkg::KW-1:0]  mem_k;
    logic [AW-1:0]            mem_addr;
    logic                     eb_we;
    logic signed [31:0]       eb_wd;
    logic                     ef_we;
    logic                     div_start;
    logic                     div_done;
    logic signed [31:0]       div_q;
    logic signed [31:0]       div_sum;

    logic signed [31:0]       eb_val;
    logic signed [31:0]       ef_val;
    logic signed [31:0]       pf;
    logic signed [31:0]       pb;
    logic signed [31:0]       tf;
    logic signed [31:0]       rate;
    logic signed [33:0]       xq;
    logic signed [33:0]       capq;
    logic signed [35:0]       rnd;
    logic signed [31:0]       add_res;
    logic signed [31:0]       rin;
    logic signed [31:0]       esat;
    logic signed [32:0]       pfmb;
    logic signed [32:0]       res_ext;
    logic signed [32:0]       res_abs;
    logic                     quiet;
    logic                     fin;
    logic                     k_last;
    logic [tbcd_pkg::KW-1:0]  k_inc;
    logic [10:0]              n_avg;

    always_comb begin
        pf      = r_pf[r_cmd.f];
        pb      = r_pb[r_cmd.f];
        tf      = r_tf[r_cmd.f];
        rate    = r_rate[r_cmd.f];
        eb_val  = r_eb_qv ? $signed(r_eb_q) : 32'sd0;
        ef_val  = r_ef_qv ? $signed(r_ef_q) : 32'sd0;
        xq      = $signed({10'd0, r_cmd.v, 12'd0});
        capq    = $signed({10'd0, r_cap[r_k[EW-1:0]], 12'd0});
        rnd     = 36'((r_prod + 52'sd32768) >>> 16);
        add_res = tbcd_pkg::sat32(64'(r_y) + 64'(rnd));
        rin     = tbcd_pkg::sat32(64'(r_prod));
        esat    = tbcd_pkg::sat32(64'(capq) - 64'(eb_val));
        pfmb    = 33'(pf) - 33'(pb);
        res_ext = 33'(add_res);
        res_abs = res_ext[32] ? -res_ext : res_ext;
        quiet   = (pfmb < tbcd_pkg::NEAR_LIMIT) && (res_abs < tbcd_pkg::RATE_LIMIT);
        fin     = r_fc >= {1'b0, i_cfg.calib};
        k_last  = r_k == tbcd_pkg::KW'(ELECTRODES_USED - 1);
        k_inc   = k_last ? '0 : r_k + 1'b1;
        n_avg   = {1'b0, i_cfg.calib} + 11'd1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbcd_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_data.kind)
                        tbcd_pkg::K_ELEC: n_state = r_cal ? tbcd_pkg::ST_EC_RD : tbcd_pkg::ST_IDLE;
                        tbcd_pkg::K_PRES: n_state = r_cal ? tbcd_pkg::ST_IDLE : tbcd_pkg::ST_P_RMUL;
                        tbcd_pkg::K_TEMP: n_state = r_cal ? tbcd_pkg::ST_T_CAL : tbcd_pkg::ST_T_MUL;
                        default:          n_state = tbcd_pkg::ST_IDLE;
                    endcase
                end
            end
            tbcd_pkg::ST_EC_RD:   n_state = tbcd_pkg::ST_EC_WR;
            tbcd_pkg::ST_EC_WR:   n_state = tbcd_pkg::ST_IDLE;
            tbcd_pkg::ST_P_RMUL:  n_state = tbcd_pkg::ST_P_FMUL;
            tbcd_pkg::ST_P_FMUL:  n_state = tbcd_pkg::ST_P_RADD;
            tbcd_pkg::ST_P_RADD:  n_state = quiet ? tbcd_pkg::ST_P_BMUL : tbcd_pkg::ST_P_FMUL2;
            tbcd_pkg::ST_P_BMUL:  n_state = tbcd_pkg::ST_P_BADD;
            tbcd_pkg::ST_P_BADD:  n_state = tbcd_pkg::ST_P_ERD;
            tbcd_pkg::ST_P_ERD:   n_state = tbcd_pkg::ST_P_EMUL;
            tbcd_pkg::ST_P_EMUL:  n_state = tbcd_pkg::ST_P_EADD;
            tbcd_pkg::ST_P_EADD:  n_state = k_last ? tbcd_pkg::ST_P_FMUL2 : tbcd_pkg::ST_P_ERD;
            tbcd_pkg::ST_P_FMUL2: n_state = tbcd_pkg::ST_P_FADD;
            tbcd_pkg::ST_P_FADD:  n_state = tbcd_pkg::ST_IDLE;
            tbcd_pkg::ST_T_CAL:   n_state = fin ? tbcd_pkg::ST_AV_RD : tbcd_pkg::ST_O_RD;
            tbcd_pkg::ST_AV_RD:   n_state = tbcd_pkg::ST_AV_GO;
            tbcd_pkg::ST_AV_GO:   n_state = tbcd_pkg::ST_AV_WAIT;
            tbcd_pkg::ST_AV_WAIT: begin
                if (div_done) begin
                    n_state = (r_sel == 2'd3 && k_last) ? tbcd_pkg::ST_O_RD : tbcd_pkg::ST_AV_RD;
                end
            end
            tbcd_pkg::ST_T_MUL:   n_state = tbcd_pkg::ST_T_ADD;
            tbcd_pkg::ST_T_ADD:   n_state = tbcd_pkg::ST_E_RD;
            tbcd_pkg::ST_E_RD:    n_state = tbcd_pkg::ST_E_MUL;
            tbcd_pkg::ST_E_MUL:   n_state = tbcd_pkg::ST_E_ADD;
            tbcd_pkg::ST_E_ADD:   n_state = tbcd_pkg::ST_E_SQ;
            tbcd_pkg::ST_E_SQ:    n_state = k_last ? tbcd_pkg::ST_E_DONE : tbcd_pkg::ST_E_RD;
            tbcd_pkg::ST_E_DONE:  n_state = tbcd_pkg::ST_O_RD;
            tbcd_pkg::ST_O_RD:    n_state = tbcd_pkg::ST_O_LOAD;
            tbcd_pkg::ST_O_LOAD:  n_state = tbcd_pkg::ST_O_WAIT;
            tbcd_pkg::ST_O_WAIT: begin
                if (i_ready) begin
                    n_state = k_last ? tbcd_pkg::ST_IDLE : tbcd_pkg::ST_O_RD;
                end
            end
            default:              n_state = tbcd_pkg::ST_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        o_pop     = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        eb_we     = 1'b0;
        eb_wd     = add_res;
        ef_we     = 1'b0;
        div_start = 1'b0;
        div_sum   = eb_val;
        mem_k     = r_k;
        case (r_state)
            tbcd_pkg::ST_IDLE:    o_pop = !i_q_empty;
            tbcd_pkg::ST_EC_RD:   mem_k = r_cmd.e;
            tbcd_pkg::ST_EC_WR: begin
                mem_k = r_cmd.e;
                eb_we = 1'b1;
                eb_wd = tbcd_pkg::sat_add(eb_val, r_cmd.v);
            end
            tbcd_pkg::ST_P_RMUL: begin
                mul_a = xq - 34'(pf);
                mul_b = tbcd_pkg::GW'(i_cfg.inv_dt);
            end
            tbcd_pkg::ST_P_FMUL: begin
                mul_a = 34'(rin) - 34'(rate);
                mul_b = tbcd_pkg::GAIN_RATE;
            end
            tbcd_pkg::ST_P_BMUL: begin
                mul_a = 34'(pf) - 34'(pb);
                mul_b = tbcd_pkg::GAIN_TRACK;
            end
            tbcd_pkg::ST_P_EMUL: begin
                mul_a = capq - 34'(eb_val);
                mul_b = tbcd_pkg::GAIN_TRACK;
            end
            tbcd_pkg::ST_P_EADD:  eb_we = 1'b1;
            tbcd_pkg::ST_P_FMUL2: begin
                mul_a = xq - 34'(pf);
                mul_b = i_cfg.gain;
            end
            tbcd_pkg::ST_AV_GO: begin
                div_start = 1'b1;
                case (r_sel)
                    2'd0:    div_sum = pf;
                    2'd1:    div_sum = pb;
                    2'd2:    div_sum = tf;
                    default: div_sum = eb_val;
                endcase
            end
            tbcd_pkg::ST_AV_WAIT: begin
                eb_we = div_done && (r_sel == 2'd3);
                eb_wd = div_q;
            end
            tbcd_pkg::ST_T_MUL: begin
                mul_a = xq - 34'(tf);
                mul_b = i_cfg.gain;
            end
            tbcd_pkg::ST_E_MUL: begin
                mul_a = 34'(esat) - 34'(ef_val);
                mul_b = i_cfg.gain;
            end
            tbcd_pkg::ST_E_ADD:   ef_we = 1'b1;
            default: begin
            end
        endcase
        mem_addr = AW'(int'(r_cmd.f) * ELECTRODES_USED + int'(mem_k));
    end

    tbcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_n     (n_avg),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // electrode stores: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (eb_we) begin
            r_eb_mem[mem_addr] <= eb_wd;
        end
        if (ef_we) begin
            r_ef_mem[mem_addr] <= add_res;
        end
        r_eb_q <= r_eb_mem[mem_addr];
        r_ef_q <= r_ef_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
        if (r_state == tbcd_pkg::ST_IDLE && !i_q_empty && i_q_data.kind == tbcd_pkg::K_ELEC
            && !r_cal) begin
            r_cap[i_q_data.e[EW-1:0]] <= i_q_data.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tbcd_pkg::ST_IDLE;
            r_cal     <= 1'b1;
            r_fc      <= '0;
            r_contact <= '0;
            r_active  <= '0;
            r_eb_vld  <= '0;
            r_ef_vld  <= '0;
            r_eb_qv   <= 1'b0;
            r_ef_qv   <= 1'b0;
            r_oval    <= 1'b0;
            r_k       <= '0;
            r_sel     <= '0;
            r_show    <= 1'b0;
            r_act     <= 1'b0;
            for (int i = 0; i < FINGERS; i++) begin
                r_pf[i]   <= '0;
                r_pb[i]   <= '0;
                r_rate[i] <= '0;
                r_tf[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_eb_qv <= r_eb_vld[mem_addr];
            r_ef_qv <= r_ef_vld[mem_addr];
            if (eb_we) begin
                r_eb_vld[mem_addr] <= 1'b1;
            end
            if (ef_we) begin
                r_ef_vld[mem_addr] <= 1'b1;
            end
            case (r_state)
                tbcd_pkg::ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_q_data;
                        if (i_q_data.kind == tbcd_pkg::K_PRES && r_cal) begin
                            r_pf[i_q_data.f] <= tbcd_pkg::sat_add(r_pf[i_q_data.f], i_q_data.v);
                            r_pb[i_q_data.f] <= tbcd_pkg::sat_add(r_pb[i_q_data.f], i_q_data.v);
                        end
                    end
                end
                tbcd_pkg::ST_P_FMUL:  r_y <= rate;
                tbcd_pkg::ST_P_RADD: begin
                    r_rate[r_cmd.f]    <= add_res;
                    r_contact[r_cmd.f] <= !quiet;
                    r_k                <= '0;
                end
                tbcd_pkg::ST_P_BMUL:  r_y <= pb;
                tbcd_pkg::ST_P_BADD:  r_pb[r_cmd.f] <= add_res;
                tbcd_pkg::ST_P_EMUL:  r_y <= eb_val;
                tbcd_pkg::ST_P_EADD:  r_k <= k_inc;
                tbcd_pkg::ST_P_FMUL2: r_y <= pf;
                tbcd_pkg::ST_P_FADD:  r_pf[r_cmd.f] <= add_res;
                tbcd_pkg::ST_T_CAL: begin
                    r_tf[r_cmd.f] <= tbcd_pkg::sat_add(tf, r_cmd.v);
                    if (int'(r_cmd.f) == FINGERS - 1) begin
                        if (fin) begin
                            r_cal <= 1'b0;
                        end else begin
                            r_fc <= r_fc + 1'b1;
                        end
                    end
                    r_show <= fin;
                    r_sel  <= '0;
                    r_k    <= '0;
                end
                tbcd_pkg::ST_AV_WAIT: begin
                    if (div_done) begin
                        case (r_sel)
                            2'd0:    r_pf[r_cmd.f] <= div_q;
                            2'd1:    r_pb[r_cmd.f] <= div_q;
                            2'd2:    r_tf[r_cmd.f] <= div_q;
                            default: r_k <= k_inc;
                        endcase
                        if (r_sel != 2'd3) begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end
                end
                tbcd_pkg::ST_T_MUL:   r_y <= tf;
                tbcd_pkg::ST_T_ADD: begin
                    r_tf[r_cmd.f] <= add_res;
                    r_k           <= '0;
                    r_act         <= 1'b0;
                    r_sq          <= '0;
                    r_show        <= 1'b1;
                end
                tbcd_pkg::ST_E_MUL:   r_y <= ef_val;
                tbcd_pkg::ST_E_ADD: begin
                    if (res_abs >= tbcd_pkg::ONE_Q12) begin
                        r_act <= 1'b1;
                        r_abs <= '0;
                    end else begin
                        r_abs <= res_abs[tbcd_pkg::VW-1:0];
                    end
                end
                tbcd_pkg::ST_E_SQ: begin
                    r_sq <= r_sq + tbcd_pkg::SQW'(r_abs * r_abs);
                    r_k  <= k_inc;
                end
                tbcd_pkg::ST_E_DONE: begin
                    r_active[r_cmd.f] <= r_act || (r_sq >= tbcd_pkg::ONE_SQ);
                end
                tbcd_pkg::ST_O_LOAD: begin
                    r_oval                    <= 1'b1;
                    o_finger_num              <= r_cmd.f;
                    o_electrode_index         <= r_k;
                    o_last                    <= k_last;
                    o_electrode_level         <= r_show ? ef_val : 32'sd0;
                    o_pressure_above_baseline <= r_show ? tbcd_pkg::sat32(64'(pfmb)) : 32'sd0;
                    if (!r_show || tf < 0) begin
                        o_temperature_level <= '0;
                    end else if (tf > 32'sd16777215) begin
                        o_temperature_level <= '1;
                    end else begin
                        o_temperature_level <= tf[tbcd_pkg::TW-1:0];
                    end
                    o_contact <= r_show && r_contact[r_cmd.f];
                    o_active  <= r_show && r_active[r_cmd.f];
                end
                tbcd_pkg::ST_O_WAIT: begin
                    if (i_ready) begin
                        r_oval <= 1'b0;
                        r_k    <= k_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_oval;

    `TBCD_ASSERT_IMPL(a_oval_in_wait, i_clk, i_rst_n, r_oval, r_state == tbcd_pkg::ST_O_WAIT)
    `TBCD_ASSERT_IMPL(a_div_in_wait, i_clk, i_rst_n, div_done, r_state == tbcd_pkg::ST_AV_WAIT)
    `TBCD_ASSERT_IMPL(a_filter_after_cal, i_clk, i_rst_n, r_state == tbcd_pkg::ST_E_DONE, !r_cal)
    `TBCD_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, r_oval && i_ready && o_last, r_state == tbcd_pkg::ST_IDLE)

endmodule

[src/tactile_baseline_contact_detector_unit.sv]
// Tactile baseline and contact detector. Sample words for each fingertip arrive tagged with a
// finger and a slot; electrode and pressure words produce no results, and each temperature word
// produces a run of 19 electrode results (last marks the final one). The front end passes each
// electrode, pressure and temperature word into a four-entry command queue, so the input keeps
// flowing while the back end works and the queue is not full. The back end runs one command at
// a time around a single shared 34x18 multiplier with a registered product. While calibrating,
// electrode, pressure and temperature words are added to their sums; afterwards an
// electrode word is captured, a pressure word updates the rate filter and contact flag, tracks
// the baselines when the fingertip is quiet and filters pressure, and a temperature word
// filters the temperature and each electrode before the result run, which waits on the output.
// At the end of calibration the 22 sums of each fingertip are averaged by a bit-serial divider.
// No clearing pass is needed after reset: the electrode stores carry per-entry valid bits.
// depends on tbcd_pkg, tbcd_front, tbcd_queue, tbcd_back
`timescale 1ns / 1ps

module tactile_baseline_contact_detector_unit #(
    parameter int FINGERS          = tbcd_pkg::FINGERS_DEF,
    parameter int ELECTRODES_USED  = tbcd_pkg::ELECTRODES_USED_DEF,
    parameter int ELECTRODE_SLOTS  = tbcd_pkg::ELECTRODE_SLOTS_DEF,
    parameter int WORDS_PER_FINGER = tbcd_pkg::WORDS_PER_FINGER_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample word channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [tbcd_pkg::FW-1:0]  i_finger_index,
    input  logic [tbcd_pkg::SW-1:0]  i_slot,
    input  logic [tbcd_pkg::VW-1:0]  i_sample_value,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [tbcd_pkg::FW-1:0]  o_finger_num,
    output logic [tbcd_pkg::KW-1:0]  o_electrode_index,
    output logic signed [31:0]       o_electrode_level,
    output logic signed [31:0]       o_pressure_above_baseline,
    output logic [tbcd_pkg::TW-1:0]  o_temperature_level,
    output logic                     o_contact,
    output logic                     o_active,
    output logic                     o_last,
    // register write port
    input  logic                     i_cfg_we,
    input  logic [tbcd_pkg::CIW-1:0] i_cfg_idx,
    input  logic [tbcd_pkg::CDW-1:0] i_cfg_data
);

    logic [tbcd_pkg::GW-1:0]  r_gain;
    logic [tbcd_pkg::DTW-1:0] r_inv_dt;
    logic [tbcd_pkg::CFW-1:0] r_calib;
    tbcd_pkg::t_cfg           cfg;

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    tbcd_pkg::t_cmd push_cmd;
    tbcd_pkg::t_cmd head_cmd;

    // register file; gains above unity act as unity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= tbcd_pkg::GAIN_RST;
            r_inv_dt <= tbcd_pkg::INVDT_RST;
            r_calib  <= tbcd_pkg::CALIB_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbcd_pkg::CFG_FILTER_GAIN:  r_gain   <= i_cfg_data;
                tbcd_pkg::CFG_INV_DT:       r_inv_dt <= i_cfg_data[tbcd_pkg::DTW-1:0];
                tbcd_pkg::CFG_CALIB_FRAMES: r_calib  <= i_cfg_data[tbcd_pkg::CFW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.gain   = (r_gain > tbcd_pkg::GAIN_ONE) ? tbcd_pkg::GAIN_ONE : r_gain;
        cfg.inv_dt = r_inv_dt;
        cfg.calib  = r_calib;
    end

    // classify words, drop the ones that carry nothing
    tbcd_front #(
        .FINGERS          (FINGERS),
        .ELECTRODES_USED  (ELECTRODES_USED),
        .ELECTRODE_SLOTS  (ELECTRODE_SLOTS),
        .WORDS_PER_FINGER (WORDS_PER_FINGER)
    ) u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_finger_index (i_finger_index),
        .i_slot         (i_slot),
        .i_sample_value (i_sample_value),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    tbcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_cmd)
    );

    // filters, baselines, calibration and the result run
    tbcd_back #(
        .FINGERS         (FINGERS),
        .ELECTRODES_USED (ELECTRODES_USED)
    ) u_back (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg                     (cfg),
        .i_q_empty                 (empty),
        .i_q_data                  (head_cmd),
        .o_pop                     (pop),
        .o_valid                   (o_valid),
        .i_ready                   (i_ready),
        .o_finger_num              (o_finger_num),
        .o_electrode_index         (o_electrode_index),
        .o_electrode_level         (o_electrode_level),
        .o_pressure_above_baseline (o_pressure_above_baseline),
        .o_temperature_level       (o_temperature_level),
        .o_contact                 (o_contact),
        .o_active                  (o_active),
        .o_last                    (o_last)
    );

endmodule
